/* hdl/ccap_pkg.sv */
// Package: shared types, codes and helper functions of the compare/capture timer.
`timescale 1ns / 1ps

package ccap_pkg;

  // Number of compare channels in use (1..3).
  localparam int unsigned COMPARE_CHANNELS = 3;
  localparam int unsigned CHAN_SLOTS       = 3;
  localparam logic [CHAN_SLOTS-1:0] CHAN_MASK = CHAN_SLOTS'((1 << COMPARE_CHANNELS) - 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE_SHIFT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_BITS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_A      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_B      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_C      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODES   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_RISING = 3'd7;

  // Operations
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_PIN     = 2'd1;
  localparam logic [1:0] OP_WR_CNT  = 2'd2;
  localparam logic [1:0] OP_WR_CAP  = 2'd3;

  // Timer modes
  localparam logic [2:0] MODE_STOP      = 3'd0;
  localparam logic [2:0] MODE_NORMAL    = 3'd1;
  localparam logic [2:0] MODE_CTC       = 3'd2;
  localparam logic [2:0] MODE_PWM_OCRA  = 3'd3;
  localparam logic [2:0] MODE_PWM_ICR   = 3'd4;
  localparam logic [2:0] MODE_FAST_PWM  = 3'd5;

  // Compare pin actions
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_TOGGLE = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_SET    = 2'd3;

  // Flag bits
  localparam int unsigned FLAG_OVF_BIT = 0;
  localparam int unsigned FLAG_CAP_BIT = 4;
  localparam logic [4:0]  FLAG_KEEP    = {1'b1, CHAN_MASK, 1'b1};

  localparam logic [3:0] SHIFT_MAX = 4'd10;
  localparam logic [4:0] BITS_MIN  = 5'd8;
  localparam logic [4:0] BITS_MAX  = 5'd16;

  typedef struct packed {
    logic [1:0]  op;
    logic        pin_level;
    logic [15:0] write_value;
    logic [4:0]  clear_mask;
  } in_word_t;

  typedef struct packed {
    logic [15:0] count;
    logic [15:0] capture_value;
    logic [4:0]  pending_flags;
    logic [2:0]  compare_pins;
  } out_word_t;

  typedef struct packed {
    logic [2:0]                   timer_mode;
    logic [3:0]                   prescale_shift;
    logic [4:0]                   counter_bits;
    logic [CHAN_SLOTS-1:0][15:0]  compare;
    logic [5:0]                   output_modes;
    logic                         capture_rising;
  } cfg_t;

  // TOP for the counter-size modes: 2^bits - 1, bits held to 8..16.
  function automatic logic [15:0] size_top(input logic [4:0] bits);
    logic [4:0]  b;
    logic [16:0] full;
    b = bits;
    if (b < BITS_MIN) b = BITS_MIN;
    if (b > BITS_MAX) b = BITS_MAX;
    full = (17'd1 << b) - 17'd1;
    return full[15:0];
  endfunction

  function automatic logic [15:0] current_top(input cfg_t cfg, input logic [15:0] cap);
    logic [15:0] t;
    unique case (cfg.timer_mode)
      MODE_CTC, MODE_PWM_OCRA: t = cfg.compare[0];
      MODE_PWM_ICR:            t = cap;
      default:                 t = size_top(cfg.counter_bits);
    endcase
    return t;
  endfunction

endpackage

/* hdl/ccap_cfg.sv */
// Configuration register file of the compare/capture timer.
`timescale 1ns / 1ps

module ccap_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ccap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccap_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ccap_pkg::cfg_t                cfg
);
  import ccap_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timer_mode     <= '0;
      cfg_r.prescale_shift <= '0;
      cfg_r.counter_bits   <= BITS_MIN;
      cfg_r.compare        <= '0;
      cfg_r.output_modes   <= '0;
      cfg_r.capture_rising <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TIMER_MODE:     cfg_r.timer_mode     <= cfg_wdata[2:0];
        REG_PRESCALE_SHIFT: cfg_r.prescale_shift <= cfg_wdata[3:0];
        REG_COUNTER_BITS:   cfg_r.counter_bits   <= cfg_wdata[4:0];
        REG_COMPARE_A:      cfg_r.compare[0]     <= cfg_wdata;
        REG_COMPARE_B:      cfg_r.compare[1]     <= cfg_wdata;
        REG_COMPARE_C:      cfg_r.compare[2]     <= cfg_wdata;
        REG_OUTPUT_MODES:   cfg_r.output_modes   <= cfg_wdata[5:0];
        REG_CAPTURE_RISING: cfg_r.capture_rising <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/ccap_core.sv */
// Timer state registers and their single-pass next-state logic.
`timescale 1ns / 1ps

module ccap_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  ccap_pkg::in_word_t  word,
  input  ccap_pkg::cfg_t      cfg,
  output ccap_pkg::out_word_t res_nxt
);
  import ccap_pkg::*;

  logic [9:0]  presc_r,  presc_nxt;
  logic [15:0] cnt_r,    cnt_nxt;
  logic [15:0] cap_r,    cap_nxt;
  logic [4:0]  flags_r,  flags_nxt;
  logic [2:0]  pins_r,   pins_nxt;
  logic        last_pin_r, last_pin_nxt;

  logic [15:0] top;
  logic [3:0]  sh;
  logic [10:0] div;
  logic [10:0] psum;
  logic        running;
  logic        edge_hit;
  logic [1:0]  act;

  always_comb begin
    top       = current_top(cfg, cap_r);
    sh        = (cfg.prescale_shift > SHIFT_MAX) ? SHIFT_MAX : cfg.prescale_shift;
    div       = 11'd1 << sh;
    psum      = {1'b0, presc_r} + 11'd1;
    running   = (cfg.timer_mode != MODE_STOP) && (cfg.timer_mode <= MODE_FAST_PWM);
    edge_hit  = cfg.capture_rising ? (!last_pin_r && word.pin_level)
                                   : (last_pin_r && !word.pin_level);
    act       = ACT_NONE;

    presc_nxt    = presc_r;
    cnt_nxt      = cnt_r;
    cap_nxt      = cap_r;
    flags_nxt    = flags_r & ~word.clear_mask;
    pins_nxt     = pins_r;
    last_pin_nxt = last_pin_r;

    unique case (word.op)
      OP_TICK: begin
        if (running) begin
          if (psum >= div) begin
            presc_nxt = '0;
            // compare matches see the count before it moves
            for (int i = 0; i < COMPARE_CHANNELS; i++) begin
              if (cfg.compare[i] != 16'd0 && cfg.compare[i] <= top &&
                  cnt_r == cfg.compare[i]) begin
                act = cfg.output_modes[2*i +: 2];
                flags_nxt[i+1] = 1'b1;
                unique case (act)
                  ACT_TOGGLE: pins_nxt[i] = ~pins_r[i];
                  ACT_CLEAR:  pins_nxt[i] = 1'b0;
                  ACT_SET:    pins_nxt[i] = 1'b1;
                  default:    pins_nxt[i] = pins_r[i];
                endcase
              end
            end
            if (cnt_r >= top) begin
              cnt_nxt                 = '0;
              flags_nxt[FLAG_OVF_BIT] = 1'b1;
            end else begin
              cnt_nxt = cnt_r + 16'd1;
            end
          end else begin
            presc_nxt = psum[9:0];
          end
        end
      end
      OP_PIN: begin
        if (edge_hit && cfg.timer_mode != MODE_PWM_ICR) begin
          cap_nxt                 = cnt_r;
          flags_nxt[FLAG_CAP_BIT] = 1'b1;
        end
        last_pin_nxt = word.pin_level;
      end
      OP_WR_CNT: cnt_nxt = (word.write_value >= top) ? 16'd0 : word.write_value;
      OP_WR_CAP: cap_nxt = word.write_value;
      default: ;
    endcase

    flags_nxt = flags_nxt & FLAG_KEEP;
    pins_nxt  = pins_nxt & CHAN_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r    <= '0;
      cnt_r      <= '0;
      cap_r      <= '0;
      flags_r    <= '0;
      pins_r     <= '0;
      last_pin_r <= 1'b0;
    end else if (en) begin
      presc_r    <= presc_nxt;
      cnt_r      <= cnt_nxt;
      cap_r      <= cap_nxt;
      flags_r    <= flags_nxt;
      pins_r     <= pins_nxt;
      last_pin_r <= last_pin_nxt;
    end
  end

  assign res_nxt.count         = cnt_nxt;
  assign res_nxt.capture_value = cap_nxt;
  assign res_nxt.pending_flags = flags_nxt;
  assign res_nxt.compare_pins  = pins_nxt;

endmodule

/* hdl/compare_capture_timer_top.sv */
// Top level of the compare/capture timer: handshakes, config and result register.
`timescale 1ns / 1ps

// Compare/capture timer. Each input word is one op: a clock tick, a sample
// of the capture pin, a counter write or a capture register write; any op
// may also clear flags through clear_mask (clear first, so a flag set by
// the same op stays set). Each accepted word yields exactly one result word
// holding the counter, capture register, pending flags and compare pin
// levels after that op. Throughput is one word per clock unless out_stall
// holds a full result register; the whole state update is one pass of
// logic between the timer state registers and the result register, so a
// word leaves in the cycle after it is taken. in_stall rises only while
// the result register is full and out_stall holds it. Config registers
// (cfg_index 0..7: mode, prescale shift, counter bits, compare a/b/c,
// output modes, capture edge) should be written while no word is in flight.

module compare_capture_timer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ccap_pkg::in_word_t              in_word,
  // result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output ccap_pkg::out_word_t             out_word,
  // config writes
  input  logic                            cfg_wr_en,
  input  logic [ccap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccap_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ccap_pkg::*;

  cfg_t      cfg;
  out_word_t res_nxt;
  out_word_t out_word_r;
  logic      out_valid_r, out_valid_nxt;
  logic      in_acc;

  ccap_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ccap_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (in_acc),
    .word    (in_word),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  // output register drains in the same cycle a new word comes in
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_word_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* hdl/ccap_chk.sv */
// Port-level checker for the compare/capture timer, bound to the top level.
`timescale 1ns / 1ps

module ccap_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input ccap_pkg::in_word_t              in_word,
  input logic                            out_valid,
  input logic                            out_stall,
  input ccap_pkg::out_word_t             out_word
);
  import ccap_pkg::*;

  // stall only back-pressures from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // every accepted word gives a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word produced no result");

  // capture register write is visible in its own result
  a_cap_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_word.op == OP_WR_CAP)
      |=> (out_word.capture_value == $past(in_word.write_value)))
    else $error("capture write not reflected");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result changed");

endmodule

bind compare_capture_timer_top ccap_chk u_ccap_chk (.*);
